// ===== rtl/frustum_aabb_cull_macros.svh =====
// Assertion macros used by the checker file.
`ifndef FRUSTUM_AABB_CULL_MACROS_SVH
`define FRUSTUM_AABB_CULL_MACROS_SVH

// Check on every clock edge outside reset.
`define FAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset cycles included.
`define FAC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/fac_pkg.sv =====
package fac_pkg;

    localparam int PLANE_COUNT_DEF = 6;
    localparam int NUM_PLANE_REGS  = 6;

    localparam int COORD_W  = 16;
    localparam int TAG_W    = 16;
    localparam int PLANE_W  = 64;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int D_SHIFT  = 14;
    // three products plus the scaled offset, exact
    localparam int DIST_W   = PROD_W + 2;

    localparam int ADDR_W    = 6;
    localparam int ADDR_LSB  = 3;
    localparam int REG_IDX_W = ADDR_W - ADDR_LSB;

    localparam int BOX_W    = 6 * COORD_W + TAG_W;
    localparam int M_DATA_W = 24;

    // first member lands in the highest bits, so min_x sits at bit 0
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] max_z;
        logic [COORD_W-1:0] max_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_z;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] min_x;
    } box_t;

    typedef struct packed {
        box_t box;
        logic vis;
    } cell_word_t;

    // normal component strictly above zero
    function automatic logic is_pos(input logic [COORD_W-1:0] n);
        return !n[COORD_W-1] && (n != '0);
    endfunction

endpackage

// ===== rtl/fac_cell.sv =====
module fac_cell
    import fac_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [PLANE_W-1:0]   plane,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cell_word_t           in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cell_word_t           out_word
);

    logic [COORD_W-1:0] nx, ny, nz, nd;
    logic [COORD_W-1:0] vx, vy, vz;

    logic signed [PROD_W-1:0] px_next, py_next, pz_next;

    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [COORD_W-1:0]       s1_d_reg;
    cell_word_t               s1_word_reg;

    logic signed [DIST_W-1:0] dist_next;
    cell_word_t               s2_word_next;

    logic                     s2_valid_reg;
    cell_word_t               s2_word_reg;

    logic s1_ready, s2_ready;

    assign nx = plane[63:48];
    assign ny = plane[47:32];
    assign nz = plane[31:16];
    assign nd = plane[15:0];

    // positive vertex
    assign vx = is_pos(nx) ? in_word.box.max_x : in_word.box.min_x;
    assign vy = is_pos(ny) ? in_word.box.max_y : in_word.box.min_y;
    assign vz = is_pos(nz) ? in_word.box.max_z : in_word.box.min_z;

    assign px_next = $signed(nx) * $signed(vx);
    assign py_next = $signed(ny) * $signed(vy);
    assign pz_next = $signed(nz) * $signed(vz);

    assign dist_next = DIST_W'(s1_px_reg) + DIST_W'(s1_py_reg) + DIST_W'(s1_pz_reg)
                     + $signed({{(DIST_W-COORD_W-D_SHIFT){s1_d_reg[COORD_W-1]}},
                                s1_d_reg, {D_SHIFT{1'b0}}});

    always_comb begin
        s2_word_next     = s1_word_reg;
        s2_word_next.vis = s1_word_reg.vis & ~dist_next[DIST_W-1];
    end

    // a stage takes a word when empty or when its content moves on
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_px_reg   <= px_next;
            s1_py_reg   <= py_next;
            s1_pz_reg   <= pz_next;
            s1_d_reg    <= nd;
            s1_word_reg <= in_word;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_word_reg <= s2_word_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_word  = s2_word_reg;

endmodule

// ===== rtl/frustum_aabb_cull.sv =====
// Throughput: one box per cycle while m_tready is high; each plane cell has a multiply stage and a sum stage.
// Every stage stalls on its own, so bubbles close up while a result waits on m_tready.
// Reset: synchronous, active-low aresetn; empties all stages and clears the plane
// registers to zero, which makes every box visible until planes are written.
module frustum_aabb_cull
    import fac_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    // box words
    input  logic                s_tvalid,
    output logic                s_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, box_tag (16 bits each, lowest first)
    input  logic [BOX_W-1:0]    s_tdata,

    // result words
    output logic                m_tvalid,
    input  logic                m_tready,
    // visible [0], result_tag [16:1], zero pad [23:17]
    output logic [M_DATA_W-1:0] m_tdata,

    // plane registers, 64 bits each at byte address 8*i
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PLANE_W-1:0]  pwdata,
    output logic [PLANE_W-1:0]  prdata,
    output logic                pready
);

    logic [PLANE_W-1:0]   plane_reg [NUM_PLANE_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 reg_hit;
    logic                 cfg_wr;

    logic       chain_valid [PLANE_COUNT+1];
    logic       chain_ready [PLANE_COUNT+1];
    cell_word_t chain_word  [PLANE_COUNT+1];

    // ------------------------------------------------------------------
    // Configuration port: zero-wait APB, one 64-bit plane per 8 bytes.
    // Writes to slots past the plane list drop silently; reads there return 0.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
    assign reg_hit = reg_idx < REG_IDX_W'(NUM_PLANE_REGS);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANE_REGS; i++) plane_reg[i] <= '0;
        end else if (cfg_wr && reg_hit) begin
            plane_reg[reg_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) prdata = plane_reg[reg_idx];
    end

    // ------------------------------------------------------------------
    // Chain head: a fresh box starts out visible.
    // ------------------------------------------------------------------
    assign chain_valid[0]    = s_tvalid;
    assign s_tready          = chain_ready[0];
    assign chain_word[0].box = box_t'(s_tdata);
    assign chain_word[0].vis = 1'b1;

    // ------------------------------------------------------------------
    // One cell per active plane. Each cell tests its own plane and hands
    // the box with the running visibility flag to its neighbor.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
        fac_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .plane     (plane_reg[g]),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_word   (chain_word[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_word  (chain_word[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Chain tail: the last cell's second stage is the output register.
    // ------------------------------------------------------------------
    assign m_tvalid                = chain_valid[PLANE_COUNT];
    assign chain_ready[PLANE_COUNT] = m_tready;
    assign m_tdata = {{(M_DATA_W - TAG_W - 1){1'b0}},
                      chain_word[PLANE_COUNT].box.tag,
                      chain_word[PLANE_COUNT].vis};

endmodule

// ===== rtl/fac_checker.sv =====
`include "frustum_aabb_cull_macros.svh"

module fac_checker
    import fac_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // hold a stalled result word
    `FAC_ASSERT(a_m_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    `FAC_ASSERT(a_m_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata changed while stalled")

    // an empty output register means no stage can be blocking the input
    `FAC_ASSERT(a_empty_takes, !m_tvalid |-> s_tready, "input stalled with empty output")

    // reset empties the chain
    `FAC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result word valid after reset")

endmodule

bind frustum_aabb_cull fac_checker u_fac_checker (.*);

// ===== sim/frustum_aabb_cull_test.sv =====
module frustum_aabb_cull_test;
    import fac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register map of the plane block, one 64-bit plane per slot. The two spare
    // slots decode inside paddr but lie past the list, so writes there are dropped.
    typedef enum int {
        PLANE_LEFT,
        PLANE_RIGHT,
        PLANE_BOTTOM,
        PLANE_TOP,
        PLANE_NEAR,
        PLANE_FAR,
        PLANE_SPARE_A,
        PLANE_SPARE_B
    } plane_sel_e;

    // How a random phase fills one plane register.
    typedef enum int {
        STYLE_ZERO,
        STYLE_FACING,
        STYLE_RANDOM,
        STYLE_ALL_ONES,
        STYLE_MAX_POS
    } plane_style_e;

    typedef struct {
        logic             visible;
        logic [TAG_W-1:0] tag;
    } cull_verdict_t;

    localparam int VIS_BIT        = 0;
    localparam int TAG_LSB        = 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_BOXES    = 125;
    localparam int PRESSURE_PHASE = 5;
    localparam int MAX_PRINTED    = 40;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // min_x, min_y, min_z, max_x, max_y, max_z, box_tag (16 bits each, lowest first)
    logic [BOX_W-1:0]    s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // visible [0], result_tag [16:1], zero pad [23:17]
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [PLANE_W-1:0]  pwdata   = '0;
    logic [PLANE_W-1:0]  prdata;
    logic                pready;

    // Shadow copy of the plane registers, updated on each completed write.
    logic [PLANE_W-1:0]  plane_copy [NUM_PLANE_REGS];

    box_t          box_queue[$];        // boxes waiting for the driver
    cull_verdict_t pending_verdicts[$]; // verdicts owed by the block, oldest first

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_send      = 1'b0;
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;

    frustum_aabb_cull DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Visibility of one box against the shadow planes. Per axis take the box
    // maximum where the normal points strictly positive, else the minimum,
    // then sum n.v plus d scaled up to the product's fraction. Any negative
    // distance culls the box; exactly zero still passes.
    function automatic cull_verdict_t predict_cull(box_t b);
        cull_verdict_t verdict;
        longint lo [3];
        longint hi [3];
        longint n;
        longint distance;
        verdict.visible = 1'b1;
        verdict.tag     = b.tag;
        lo[0] = longint'($signed(b.min_x));
        lo[1] = longint'($signed(b.min_y));
        lo[2] = longint'($signed(b.min_z));
        hi[0] = longint'($signed(b.max_x));
        hi[1] = longint'($signed(b.max_y));
        hi[2] = longint'($signed(b.max_z));
        for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
            distance = longint'($signed(plane_copy[p][COORD_W-1:0])) * (longint'(1) << D_SHIFT);
            for (int k = 0; k < 3; k++) begin
                // nx sits in the top 16 bits, then ny, then nz
                n = longint'($signed(plane_copy[p][PLANE_W-1-COORD_W*k -: COORD_W]));
                distance += n * ((n > 0) ? hi[k] : lo[k]);
            end
            if (distance < 0)
                verdict.visible = 1'b0;
        end
        return verdict;
    endfunction

    function automatic box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz, int tag);
        box_t b;
        b.min_x = lx[COORD_W-1:0];
        b.min_y = ly[COORD_W-1:0];
        b.min_z = lz[COORD_W-1:0];
        b.max_x = hx[COORD_W-1:0];
        b.max_y = hy[COORD_W-1:0];
        b.max_z = hz[COORD_W-1:0];
        b.tag   = tag[TAG_W-1:0];
        return b;
    endfunction

    function automatic logic [PLANE_W-1:0] plane_word(int nx, int ny, int nz, int d);
        return {nx[COORD_W-1:0], ny[COORD_W-1:0], nz[COORD_W-1:0], d[COORD_W-1:0]};
    endfunction

    // Mostly compact boxes near the origin so that planes cut through them;
    // some with corners swapped, some with every field fully random.
    function automatic box_t random_box();
        int lo [3];
        int hi [3];
        int c;
        int h;
        int t;
        if ($urandom_range(0, 99) < 15)
            return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom);
        for (int k = 0; k < 3; k++) begin
            c = int'($urandom_range(0, 4095)) - 2048;
            h = $urandom_range(0, 512);
            lo[k] = c - h;
            hi[k] = c + h;
            if ($urandom_range(0, 99) < 10) begin
                t = lo[k];
                lo[k] = hi[k];
                hi[k] = t;
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom);
    endfunction

    function automatic logic [PLANE_W-1:0] plane_for(plane_style_e style);
        case (style)
            STYLE_ZERO:     return '0;
            STYLE_FACING:   return plane_word(int'($urandom_range(0, 32768)) - 16384,
                                              int'($urandom_range(0, 32768)) - 16384,
                                              int'($urandom_range(0, 32768)) - 16384,
                                              int'($urandom_range(0, 5119)) - 1024);
            STYLE_RANDOM:   return {$urandom, $urandom};
            STYLE_ALL_ONES: return '1;
            default:        return plane_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        endcase
    endfunction

    function automatic plane_style_e style_for(int phase, int sel);
        case (phase)
            0:       return (sel == PLANE_LEFT) ? STYLE_FACING : STYLE_ZERO;
            1:       return (sel <= PLANE_RIGHT) ? STYLE_FACING : STYLE_ZERO;
            2:       return STYLE_FACING;
            3:       return STYLE_RANDOM;
            4:       return STYLE_ALL_ONES;
            5:       return STYLE_FACING;
            6:       return plane_style_e'($urandom_range(STYLE_ZERO, STYLE_RANDOM));
            default: return STYLE_MAX_POS;
        endcase
    endfunction

    // Append one box to the driver's queue.
    task automatic queue_box(input box_t b);
        box_queue = {box_queue, b};
    endtask

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Compare one result word with the oldest owed verdict, field by field.
    task automatic check_verdict(input logic [M_DATA_W-1:0] word);
        cull_verdict_t want;
        if (pending_verdicts.size() == 0) begin
            flag_mismatch($sformatf("result word %h with nothing owed", word));
            return;
        end
        want = pending_verdicts.pop_front();
        if (word[VIS_BIT] !== want.visible)
            flag_mismatch($sformatf("tag %h: visible %b, want %b",
                                    want.tag, word[VIS_BIT], want.visible));
        if (word[TAG_LSB +: TAG_W] !== want.tag)
            flag_mismatch($sformatf("result_tag %h, want %h", word[TAG_LSB +: TAG_W], want.tag));
    endtask

    // APB write: setup cycle, then access until pready. The register takes the
    // value at the access edge, so update the shadow right after it.
    task automatic write_plane(input int sel, input logic [PLANE_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(sel << ADDR_LSB);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel < NUM_PLANE_REGS)
            plane_copy[sel] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold until every queued box is taken and every verdict has come back,
    // then let the pipe settle before touching the registers. Sample on the
    // falling edge so the driver's updates from the rising edge have landed.
    task automatic drain();
        while (box_queue.size() != 0 || s_tvalid || pending_verdicts.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_all_planes(input logic [PLANE_W-1:0] value);
        for (int sel = PLANE_LEFT; sel <= PLANE_FAR; sel++)
            write_plane(sel, value);
    endtask

    // Driver: present the next box once the current word is taken or the
    // bus is empty. Predict at the accepting edge, against current planes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                pending_verdicts = {pending_verdicts, predict_cull(box_t'(s_tdata))};
            if (!s_tvalid || s_tready) begin
                if (box_queue.size() != 0 && !hold_send &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata  <= box_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result word, stall the result side at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_verdict(m_tdata);
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: any handshake on either stream or the APB port counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < NUM_PLANE_REGS; i++)
            plane_copy[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Planes straight out of reset: all zero, so every box passes.
        queue_box(make_box(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           16'h8000, 16'h0000));
        queue_box(make_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 16'hFFFF));
        queue_box(make_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                           16'h8000, 16'h0001));
        drain();

        // Hand-built planes: left keeps x_max >= 0, right keeps x_min <= 256,
        // bottom and top keep y_max, z_max >= 0 (zero normals take the
        // minimum), near and far stay open. Junk to the spare slots is dropped.
        write_plane(PLANE_LEFT,   plane_word(16'h4000, 0, 0, 0));
        write_plane(PLANE_RIGHT,  plane_word(16'hC000, 0, 0, 16'h0100));
        write_plane(PLANE_BOTTOM, plane_word(0, 16'h4000, 0, 0));
        write_plane(PLANE_TOP,    plane_word(0, 0, 16'h4000, 0));
        write_plane(PLANE_NEAR,   '0);
        write_plane(PLANE_FAR,    '0);
        write_plane(PLANE_SPARE_A, '1);
        write_plane(PLANE_SPARE_B, plane_word(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        queue_box(make_box(-16, 0, 0, 16, 0, 0, 16'h0010));   // distances hit zero
        queue_box(make_box(-16, 0, 0, -1, 0, 0, 16'h0011));   // left just fails
        queue_box(make_box(257, 0, 0, 300, 0, 0, 16'h0012));  // right just fails
        queue_box(make_box(256, 0, 0, 300, 0, 0, 16'h0013));  // right exactly zero
        queue_box(make_box(16, 0, 0, -16, 0, 0, 16'h0014));   // corners swapped
        queue_box(make_box(0, -8, 0, 0, -1, 0, 16'h0015));
        queue_box(make_box(0, 0, -8, 0, 0, -1, 16'h0016));
        queue_box(make_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 16'h0017));
        drain();

        // Most negative normals and offset everywhere: the minimum corner decides.
        write_all_planes(plane_word(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        queue_box(make_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 16'h0020));
        queue_box(make_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 16'h0021));
        drain();

        // Most positive everywhere: the maximum corner decides.
        write_all_planes(plane_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        queue_box(make_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 16'h0030));
        queue_box(make_box(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           16'h8000, 16'h0031));
        drain();

        // All ones: tiny negative normals, offset -1 LSB.
        write_all_planes('1);
        queue_box(make_box(16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 16'h0040));
        queue_box(make_box(0, 0, 0, 0, 0, 0, 16'h0041));
        queue_box(make_box(-16384, 0, 0, 0, 0, 0, 16'h0042)); // exactly zero
        drain();

        // Random phases: fresh planes each time, rotating through idle patterns.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int sel = PLANE_LEFT; sel <= PLANE_FAR; sel++)
                write_plane(sel, plane_for(style_for(phase, sel)));
            if (phase == 3) begin
                write_plane(PLANE_SPARE_A, {$urandom, $urandom});
                write_plane(PLANE_SPARE_B, {$urandom, $urandom});
            end
            for (int i = 0; i < PHASE_BOXES; i++)
                queue_box(random_box());
            if (phase == PRESSURE_PHASE) begin
                // Hold the sender midway until the block has fully emptied.
                while (box_queue.size() > PHASE_BOXES / 2)
                    @(posedge aclk);
                hold_send <= 1'b1;
                do @(posedge aclk); while (s_tvalid || pending_verdicts.size() != 0);
                hold_send <= 1'b0;
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
